/* hdl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/itew_pkg.sv */
// types and constants for the integer to english word token block
package itew_pkg;

  localparam int NUM_W    = 31;
  localparam int TOK_W    = 5;
  localparam int DIGITS   = 10;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int CNT_W    = $clog2(NUM_W);

  localparam logic [TOK_W-1:0] TOK_ZERO     = 5'd0;
  localparam logic [TOK_W-1:0] TOK_TWENTY   = 5'd20;
  localparam logic [TOK_W-1:0] TOK_HUNDRED  = 5'd28;
  localparam logic [TOK_W-1:0] TOK_THOUSAND = 5'd29;

  // decimal digits handed from the converter to the token walker
  typedef struct packed {
    logic             valid;
    logic [BCD_W-1:0] digits;
  } itew_bcd_t;

endpackage

/* hdl/itew_if.sv */
// valid/ready channel interfaces for number in and word tokens out
interface itew_num_if;
  import itew_pkg::*;
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface itew_tok_if;
  import itew_pkg::*;
  logic             valid;
  logic             ready;
  logic [TOK_W-1:0] word_token;
  logic             last_word;

  modport source (output valid, output word_token, output last_word, input ready);
  modport sink (input valid, input word_token, input last_word, output ready);
endinterface

/* hdl/itew_dabble.sv */
// bit-serial binary to bcd converter (shift and add three)
module itew_dabble import itew_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [NUM_W-1:0] in_number_i,
  output logic             in_ready_o,
  output itew_bcd_t        bcd_o,
  input  logic             bcd_take_i
);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] bin_q;
  logic [BCD_W-1:0] bcd_q;
  logic [BCD_W-1:0] adj;

  assign in_ready_o = !busy_q && !done_q;

  // digits of five or more get three added before the shift
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3 : bcd_q[4*k +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (done_q && bcd_take_i) begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      bin_q <= in_number_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[NUM_W-2:0], 1'b0};
      bcd_q <= {adj[BCD_W-2:0], bin_q[NUM_W-1]};
    end
  end

  assign bcd_o.valid  = done_q;
  assign bcd_o.digits = bcd_q;

endmodule

/* hdl/itew_emit.sv */
// walks the decimal groups and emits at most one word token per step
module itew_emit import itew_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  itew_bcd_t        bcd_i,
  output logic             bcd_take_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [TOK_W-1:0] out_token_o,
  output logic             out_last_o
);

  localparam logic [2:0] ST_HUND  = 3'd0;
  localparam logic [2:0] ST_HWORD = 3'd1;
  localparam logic [2:0] ST_TENS  = 3'd2;
  localparam logic [2:0] ST_ONES  = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;

  logic             busy_q;
  logic             zero_q;
  logic [1:0]       grp_q;
  logic [2:0]       step_q;
  logic [BCD_W-1:0] dig_q;
  logic             out_valid_q;
  logic [TOK_W-1:0] out_token_q;
  logic             out_last_q;

  logic [47:0]      ext;
  logic [3:0]       h, t, o;
  logic [DIGITS-1:0] nz;
  logic             lower_nz;
  logic [4:0]       e;
  logic [4:0]       e_hi;
  logic             emit_now;
  logic             last_now;
  logic [TOK_W-1:0] tok_now;
  logic             slot_free;
  logic             advance;
  logic             finish;

  assign bcd_take_o = bcd_i.valid && !busy_q;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    ext = {8'b0, dig_q};
    for (int k = 0; k < DIGITS; k++) begin
      nz[k] = dig_q[4*k +: 4] != 4'd0;
    end
    // billion group is the single top digit
    case (grp_q)
      2'd0: begin
        h = ext[47:44]; t = ext[43:40]; o = ext[39:36];
        lower_nz = |nz[8:0];
      end
      2'd1: begin
        h = ext[35:32]; t = ext[31:28]; o = ext[27:24];
        lower_nz = |nz[5:0];
      end
      2'd2: begin
        h = ext[23:20]; t = ext[19:16]; o = ext[15:12];
        lower_nz = |nz[2:0];
      end
      default: begin
        h = ext[11:8]; t = ext[7:4]; o = ext[3:0];
        lower_nz = 1'b0;
      end
    endcase
  end

  always_comb begin
    e[0] = h != 4'd0;
    e[1] = h != 4'd0;
    e[2] = (t != 4'd0) || (o != 4'd0);
    e[3] = (t >= 4'd2) && (o != 4'd0);
    e[4] = ((h != 4'd0) || (t != 4'd0) || (o != 4'd0)) && (grp_q != 2'd3);
    e_hi = e >> step_q;

    case (step_q)
      ST_HUND: begin
        emit_now = e[0];
        tok_now  = {1'b0, h};
      end
      ST_HWORD: begin
        emit_now = e[1];
        tok_now  = TOK_HUNDRED;
      end
      ST_TENS: begin
        emit_now = e[2];
        // teens fold both digits into one word
        if (t >= 4'd2) tok_now = TOK_TWENTY + {1'b0, t} - 5'd2;
        else if (t == 4'd1) tok_now = 5'd10 + {1'b0, o};
        else tok_now = {1'b0, o};
      end
      ST_ONES: begin
        emit_now = e[3];
        tok_now  = {1'b0, o};
      end
      ST_SCALE: begin
        emit_now = e[4];
        tok_now  = TOK_THOUSAND + 5'd2 - {3'b0, grp_q};
      end
      default: begin
        emit_now = 1'b0;
        tok_now  = TOK_ZERO;
      end
    endcase

    if (zero_q) begin
      emit_now = 1'b1;
      tok_now  = TOK_ZERO;
    end
    last_now = zero_q || (!(|e_hi[4:1]) && !lower_nz);
    finish   = zero_q || (emit_now && last_now) || (step_q == ST_SCALE && grp_q == 2'd3);
    advance  = busy_q && (!emit_now || slot_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      zero_q      <= 1'b0;
      grp_q       <= '0;
      step_q      <= ST_HUND;
      out_valid_q <= 1'b0;
    end else begin
      if (bcd_take_o) begin
        busy_q <= 1'b1;
        zero_q <= bcd_i.digits == '0;
        grp_q  <= '0;
        step_q <= ST_HUND;
      end else if (advance) begin
        if (finish) begin
          busy_q <= 1'b0;
        end else if (step_q == ST_SCALE) begin
          step_q <= ST_HUND;
          grp_q  <= grp_q + 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (slot_free) begin
        out_valid_q <= busy_q && emit_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bcd_take_o) begin
      dig_q <= bcd_i.digits;
    end
    if (slot_free && busy_q && emit_now) begin
      out_token_q <= tok_now;
      out_last_q  <= last_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_token_o = out_token_q;
  assign out_last_o  = out_last_q;

endmodule

/* hdl/integer_to_english_word_tokens.sv */
// Converts a 31-bit unsigned number into its English wording as a stream of
// word tokens (0 Zero, 1-19 One..Nineteen, 20-27 Twenty..Ninety, 28 Hundred,
// 29 Thousand, 30 Million, 31 Billion), with last_word set on the final beat.
// The bit-serial binary to decimal converter shifts in one input bit per cycle
// and holds a number's digits until the token walker takes them, taking no
// new number before then. The token walker walks up to five steps in each of
// the four groups (hundreds digit, Hundred, tens, ones, scale word; one token
// or one skipped word per step) and runs while the next number is being
// converted. Output stalls simply hold the walker.
`include "assert_macros.svh"

module integer_to_english_word_tokens import itew_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  itew_num_if.sink   num_i,
  itew_tok_if.source tok_o
);

  itew_bcd_t bcd;
  logic      bcd_take;

  itew_dabble u_dabble (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (num_i.valid),
    .in_number_i (num_i.number),
    .in_ready_o  (num_i.ready),
    .bcd_o       (bcd),
    .bcd_take_i  (bcd_take)
  );

  itew_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bcd_i       (bcd),
    .bcd_take_o  (bcd_take),
    .out_valid_o (tok_o.valid),
    .out_ready_i (tok_o.ready),
    .out_token_o (tok_o.word_token),
    .out_last_o  (tok_o.last_word)
  );

  // zero only ever comes as a wording of its own
  `ASSERT_IMP(a_zero_alone, tok_o.valid && tok_o.word_token == TOK_ZERO, tok_o.last_word, "lone zero")
  // converter is busy right after taking a number
  `ASSERT_NXT(a_busy_after_take, num_i.valid && num_i.ready, !num_i.ready, "two numbers taken")
  // converted digits hold until the walker takes them
  `ASSERT_NXT(a_bcd_hold, bcd.valid && !bcd_take, bcd.valid && $stable(bcd.digits), "bcd lost")

endmodule
